FILE: rtl/bma_pkg.sv
package bma_pkg;

   localparam int SAMPLE_FIELD_W = 16;
   localparam int BIN_COUNT_W    = 7;
   localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RESET = 7'd64;

   typedef enum logic {
      CMD_ACCUMULATE = 1'b0,
      CMD_READ       = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      STATUS_DONE         = 3'd0,
      STATUS_BIN_ZERO     = 3'd1,
      STATUS_NAN          = 3'd2,
      STATUS_OUT_OF_RANGE = 3'd3,
      STATUS_FULL         = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type                           cmd;
      logic [3:0]                        channel;
      logic signed [7:0]                 bin_index;
      logic signed [SAMPLE_FIELD_W-1:0]  sample;
      logic                              sample_is_nan;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [31:0]        entry_count;
      logic signed [47:0] entry_sum;
      logic [63:0]        entry_sum_squares;
      logic [31:0]        nan_total;
   } rsp_type;

   // one table entry
   typedef struct packed {
      logic [31:0] count;
      logic [47:0] sum;
      logic [63:0] sum_sq;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;         // latch request, classify it
      logic clear_write;  // zero one entry of the clearing sweep
      logic lookup;       // read addressed entry, form square
      logic commit;       // update entry, load response register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
   } dp_stat_type;

endpackage

FILE: rtl/bma_ctrl.sv
module bma_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bma_pkg::ctrl_cmd_type ctrl_cmd,
   input  bma_pkg::dp_stat_type  dp_stat
);
   import bma_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_READ   = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      commit;

   // result register free, or being emptied this cycle
   assign commit = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (dp_stat.clear_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: if (commit) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign ctrl_cmd.load        = (state_ff == ST_IDLE) && req_valid;
   assign ctrl_cmd.clear_write = (state_ff == ST_CLEAR);
   assign ctrl_cmd.lookup      = (state_ff == ST_READ);
   assign ctrl_cmd.commit      = commit;

endmodule

FILE: rtl/bma_datapath.sv
module bma_datapath #(
   parameter int CHANNELS     = 16,
   parameter int MAX_BINS     = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bma_pkg::req_type      req_data,
   output bma_pkg::rsp_type      rsp_data,
   input  logic                  csr_write_enable,
   input  logic [6:0]            csr_write_data,
   input  bma_pkg::ctrl_cmd_type ctrl_cmd,
   output bma_pkg::dp_stat_type  dp_stat
);
   import bma_pkg::*;

   localparam int ENTRIES = CHANNELS * MAX_BINS;
   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LIM_W   = ($clog2(MAX_BINS + 1) > BIN_COUNT_W) ?
                            $clog2(MAX_BINS + 1) : BIN_COUNT_W;
   localparam int SQ_W    = 2 * SAMPLE_WIDTH;

   // table
   entry_type entry_mem_ff [ENTRIES];

   logic [BIN_COUNT_W-1:0]         bin_count_ff;
   logic [31:0]                    nan_counter_ff, nan_counter_in;
   logic [ADDR_W-1:0]              clear_addr_ff;

   cmd_type                        cmd_ff;
   status_type                     status_pre_ff, status_pre_in;
   logic [ADDR_W-1:0]              addr_ff, addr_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   entry_type                      rd_ff;
   logic signed [SQ_W-1:0]         square_ff;
   rsp_type                        rsp_data_ff, rsp_data_in;

   logic [SAMPLE_WIDTH+SAMPLE_FIELD_W-1:0] sample_wide;
   logic [LIM_W-1:0]               limit, bin_ext, bin_count_ext;
   logic                           out_of_range;
   logic                           mem_we;
   logic [ADDR_W-1:0]              mem_waddr;
   entry_type                      mem_wdata, entry_new;
   logic                           entry_full;

   // Sample: low SAMPLE_WIDTH bits of the field, zero-filled above it
   assign sample_wide = {{SAMPLE_WIDTH{1'b0}}, req_data.sample};
   assign sample_in   = sample_wide[SAMPLE_WIDTH-1:0];

   // Range check and classification at load
   always_comb begin
      bin_count_ext = LIM_W'(bin_count_ff);
      bin_ext       = LIM_W'(req_data.bin_index[6:0]);
      limit         = (bin_count_ext < LIM_W'(MAX_BINS)) ? bin_count_ext : LIM_W'(MAX_BINS);
      out_of_range  = req_data.bin_index[7] || (bin_ext > limit) ||
                      (32'(req_data.channel) >= 32'(CHANNELS));
      priority if (out_of_range) begin
         status_pre_in = STATUS_OUT_OF_RANGE;
      end else if (req_data.cmd == CMD_ACCUMULATE && req_data.sample_is_nan) begin
         status_pre_in = STATUS_NAN;
      end else if (req_data.bin_index == 8'sd0) begin
         status_pre_in = STATUS_BIN_ZERO;
      end else begin
         status_pre_in = STATUS_DONE;
      end
      addr_in = ADDR_W'(32'(req_data.channel) * 32'(MAX_BINS) +
                        32'(req_data.bin_index[6:0]) - 32'd1);
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         cmd_ff        <= req_data.cmd;
         status_pre_ff <= status_pre_in;
         addr_ff       <= addr_in;
         sample_ff     <= sample_in;
      end
   end

   // Lookup: registered table read, square in parallel
   always_ff @(posedge clock) begin
      if (ctrl_cmd.lookup) begin
         rd_ff     <= entry_mem_ff[addr_ff];
         square_ff <= sample_ff * sample_ff;
      end
   end

   // Update
   assign entry_full             = (rd_ff.count == 32'hFFFF_FFFF);
   assign entry_new.count        = rd_ff.count + 32'd1;
   assign entry_new.sum          = rd_ff.sum + 48'(sample_ff);
   assign entry_new.sum_sq       = rd_ff.sum_sq + 64'(square_ff);

   always_comb begin
      nan_counter_in = nan_counter_ff;
      if (ctrl_cmd.commit && status_pre_ff == STATUS_NAN &&
          nan_counter_ff != 32'hFFFF_FFFF) begin
         nan_counter_in = nan_counter_ff + 32'd1;
      end
   end

   always_comb begin
      rsp_data_in.status            = status_pre_ff;
      rsp_data_in.entry_count       = '0;
      rsp_data_in.entry_sum         = '0;
      rsp_data_in.entry_sum_squares = '0;
      rsp_data_in.nan_total         = nan_counter_in;
      unique case (status_pre_ff)
         STATUS_DONE: begin
            priority if (cmd_ff == CMD_READ || entry_full) begin
               rsp_data_in.status            = (cmd_ff == CMD_READ) ? STATUS_DONE : STATUS_FULL;
               rsp_data_in.entry_count       = rd_ff.count;
               rsp_data_in.entry_sum         = rd_ff.sum;
               rsp_data_in.entry_sum_squares = rd_ff.sum_sq;
            end else begin
               rsp_data_in.entry_count       = entry_new.count;
               rsp_data_in.entry_sum         = entry_new.sum;
               rsp_data_in.entry_sum_squares = entry_new.sum_sq;
            end
         end
         default: begin
            rsp_data_in.status = status_pre_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.commit) rsp_data_ff <= rsp_data_in;
   end

   // Single write port: clearing sweep or write-back
   assign mem_we    = ctrl_cmd.clear_write ||
                      (ctrl_cmd.commit && status_pre_ff == STATUS_DONE &&
                       cmd_ff == CMD_ACCUMULATE && !entry_full);
   assign mem_waddr = ctrl_cmd.clear_write ? clear_addr_ff : addr_ff;
   assign mem_wdata = ctrl_cmd.clear_write ? entry_type'('0) : entry_new;

   always_ff @(posedge clock) begin
      if (mem_we) entry_mem_ff[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff   <= BIN_COUNT_RESET;
         nan_counter_ff <= '0;
         clear_addr_ff  <= '0;
      end else begin
         if (csr_write_enable) bin_count_ff <= csr_write_data;
         nan_counter_ff <= nan_counter_in;
         if (ctrl_cmd.clear_write) clear_addr_ff <= clear_addr_ff + ADDR_W'(1);
      end
   end

   assign dp_stat.clear_last = (clear_addr_ff == ADDR_W'(ENTRIES - 1));
   assign rsp_data           = rsp_data_ff;

endmodule

FILE: rtl/binned_moment_accumulator.sv
// After a request is accepted, the read step and then the update step follow;
//   the update step registers the response and waits while an earlier one is stalled.
// A new request is taken only once the table read, square and write-back of the
//   last one are done; the entry table has a single write port.
// A stalled response holds the update step, so req_stall stays high meanwhile.
// Reset (synchronous): a clearing sweep zeroes all CHANNELS*MAX_BINS entries
//   (1024 by default) with req_stall high; csr writes taken throughout.
module binned_moment_accumulator #(
   parameter int CHANNELS     = 16,
   parameter int MAX_BINS     = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  bma_pkg::req_type req_data,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bma_pkg::rsp_type rsp_data,
   // bin_count register
   input  logic             csr_write_enable,
   input  logic [6:0]       csr_write_data
);
   import bma_pkg::*;

   ctrl_cmd_type ctrl_cmd;
   dp_stat_type  dp_stat;

   // Sequencer: clear sweep, then idle -> read -> update per request.
   // The update step holds while the response register is still full and stalled.
   bma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl_cmd  (ctrl_cmd),
      .dp_stat   (dp_stat)
   );

   // Datapath: classification, entry table, squarer, adders, NaN counter,
   // bin_count register and the response register.
   bma_datapath #(
      .CHANNELS     (CHANNELS),
      .MAX_BINS     (MAX_BINS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .ctrl_cmd         (ctrl_cmd),
      .dp_stat          (dp_stat)
   );

endmodule

FILE: rtl/bma_checker.sv
module bma_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bma_pkg::rsp_type rsp_data
);
   import bma_pkg::*;

   // one request at a time: the cycle after an accept is stalled
   a_accept_then_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted on consecutive cycles");

   // entry fields are zero unless an entry was addressed
   a_no_entry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_BIN_ZERO ||
                    rsp_data.status == STATUS_NAN ||
                    rsp_data.status == STATUS_OUT_OF_RANGE)
      |-> rsp_data.entry_count == 32'd0 && rsp_data.entry_sum == 48'sd0 &&
          rsp_data.entry_sum_squares == 64'd0)
      else $error("entry fields set without an addressed entry");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("response changed while stalled");

endmodule

bind binned_moment_accumulator bma_checker u_bma_checker (.*);
